### hdl/window_average_and_peak_stats_macros.svh
// Assertion macros shared by the window statistics RTL.
// No dependencies; included by files that carry concurrent checks on clk and arst_n.
`ifndef WINDOW_AVERAGE_AND_PEAK_STATS_MACROS_SVH
`define WINDOW_AVERAGE_AND_PEAK_STATS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define WAPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("window stats check failed");
// next-cycle implication, disabled during reset
`define WAPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("window stats check failed");
`else
`define WAPS_ASSERT_NOW(label, ante, cons)
`define WAPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/wavgpk_pkg.sv
// Shared constants and types for the window average and peak statistics block.
// No dependencies; used by wavgpk_div and window_average_and_peak_stats.
package wavgpk_pkg;

	localparam int HISTORY_DEPTH = 64;
	localparam int SAMPLE_BITS   = 24;
	localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
	localparam int COUNT_BITS    = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_BITS      = SAMPLE_BITS + ADDR_BITS;
	localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

	// control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_LAST,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hdl/wavgpk_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, for the window average.
// Depends on wavgpk_pkg for widths and the status struct.
module wavgpk_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [wavgpk_pkg::SUM_BITS-1:0]      dividend,
	input  logic [wavgpk_pkg::COUNT_BITS-1:0]    divisor,
	output logic [wavgpk_pkg::SUM_BITS-1:0]      quotient,
	output wavgpk_pkg::div_stat_t                stat
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [wavgpk_pkg::DIV_CNT_BITS-1:0]   cnt_q;
	logic [wavgpk_pkg::COUNT_BITS-1:0]     rem_q;
	logic [wavgpk_pkg::COUNT_BITS-1:0]     dsr_q;
	logic [wavgpk_pkg::SUM_BITS-1:0]       quo_q;
	logic [wavgpk_pkg::COUNT_BITS:0]       rem_sh;
	logic [wavgpk_pkg::COUNT_BITS:0]       rem_diff;
	logic                                  q_bit;
	logic [wavgpk_pkg::COUNT_BITS-1:0]     rem_next;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh   = {rem_q, quo_q[wavgpk_pkg::SUM_BITS-1]};
		rem_diff = rem_sh - {1'b0, dsr_q};
		q_bit    = (rem_sh >= {1'b0, dsr_q});
		rem_next = q_bit ? rem_diff[wavgpk_pkg::COUNT_BITS-1:0]
			: rem_sh[wavgpk_pkg::COUNT_BITS-1:0];
	end

	// control: busy flag, bit counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= wavgpk_pkg::DIV_CNT_BITS'(wavgpk_pkg::SUM_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[wavgpk_pkg::SUM_BITS-2:0], q_bit};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/window_average_and_peak_stats.sv
// Window average and peak statistics: top level with history memory and sequencer.
// Depends on wavgpk_pkg, wavgpk_div and window_average_and_peak_stats_macros.svh.
//
// Usage:
//  Input channel (in_valid/in_ready) carries sample_us and recompute. Each item
//  writes sample_us into a 64-entry circular history. Output channel
//  (out_valid/out_ready) returns one item per input: the sample just stored
//  and the held average, maximum and nonzero count.
//  An item without recompute goes straight to the final state, which loads
//  its result into the output register. With recompute the sequencer walks
//  the history memory one entry per cycle, then runs a bit-serial divider,
//  before the final state. One item is in work at a time, and the next item
//  is taken the cycle after the current result has moved into the output
//  register.
//  Reset: the history reads as all zero (a fill count masks entries never
//  written), pointer and held statistics clear to zero. No clearing pass.
//  A stalled receiver holds the result in the output register; the block
//  waits in its final state until that register frees.
module window_average_and_peak_stats (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [23:0]                           sample_us,
	input  logic                                  recompute,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [23:0]                           last_sample,
	output logic [23:0]                           average,
	output logic [23:0]                           maximum,
	output logic [6:0]                            valid_count
);

	`include "window_average_and_peak_stats_macros.svh"

	wavgpk_pkg::state_t                        state_q;
	wavgpk_pkg::state_t                        state_nxt;

	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        hist_mem [wavgpk_pkg::HISTORY_DEPTH];
	logic [wavgpk_pkg::ADDR_BITS-1:0]          wr_ptr_q;
	logic [wavgpk_pkg::COUNT_BITS-1:0]         fill_q;
	logic [wavgpk_pkg::ADDR_BITS-1:0]          rd_idx_q;
	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        rd_data_s1;
	logic                                      rd_vld_s1;
	logic                                      rd_live_s1;

	logic [wavgpk_pkg::SUM_BITS-1:0]           sum_acc_q;
	logic [wavgpk_pkg::COUNT_BITS-1:0]         cnt_acc_q;
	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        max_acc_q;

	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        samp_q;
	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        avg_h_q;
	logic [wavgpk_pkg::SAMPLE_BITS-1:0]        max_h_q;
	logic [wavgpk_pkg::COUNT_BITS-1:0]         cnt_h_q;

	logic                                      out_valid_q;
	logic [23:0]                               out_last_q;
	logic [23:0]                               out_avg_q;
	logic [23:0]                               out_max_q;
	logic [6:0]                                out_cnt_q;

	logic                                      in_acc;
	logic                                      rd_issue;
	logic                                      div_start;
	logic                                      out_load;
	logic [wavgpk_pkg::SUM_BITS-1:0]           div_quo;
	wavgpk_pkg::div_stat_t                     div_stat;

	assign in_ready = (state_q == wavgpk_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		rd_issue  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			wavgpk_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_nxt = recompute ? wavgpk_pkg::ST_WALK : wavgpk_pkg::ST_FINISH;
				end
			end
			wavgpk_pkg::ST_WALK: begin
				rd_issue = 1'b1;
				if (rd_idx_q == wavgpk_pkg::ADDR_BITS'(wavgpk_pkg::HISTORY_DEPTH - 1)) begin
					state_nxt = wavgpk_pkg::ST_LAST;
				end
			end
			wavgpk_pkg::ST_LAST: begin
				state_nxt = wavgpk_pkg::ST_DIV_GO;
			end
			wavgpk_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_nxt = wavgpk_pkg::ST_DIV_WAIT;
			end
			wavgpk_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_nxt = wavgpk_pkg::ST_FINISH;
				end
			end
			wavgpk_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load  = 1'b1;
					state_nxt = wavgpk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = wavgpk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wavgpk_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// history memory: write on accept, registered read during the walk
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist_mem[wr_ptr_q] <= sample_us;
		end
		rd_data_s1 <= hist_mem[rd_idx_q];
	end

	// write pointer with wrap, fill count of entries ever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (in_acc) begin
			wr_ptr_q <= (wr_ptr_q == wavgpk_pkg::ADDR_BITS'(wavgpk_pkg::HISTORY_DEPTH - 1))
				? '0 : wr_ptr_q + 1'b1;
			if (fill_q != wavgpk_pkg::COUNT_BITS'(wavgpk_pkg::HISTORY_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// walk address and read-stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_issue;
			rd_live_s1 <= (wavgpk_pkg::COUNT_BITS'(rd_idx_q) < fill_q);
			if (in_acc) begin
				rd_idx_q <= '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// count, sum and peak of nonzero entries
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_acc_q <= '0;
			cnt_acc_q <= '0;
			max_acc_q <= '0;
		end else if (rd_vld_s1 && rd_live_s1 && (rd_data_s1 != '0)) begin
			sum_acc_q <= sum_acc_q + wavgpk_pkg::SUM_BITS'(rd_data_s1);
			cnt_acc_q <= cnt_acc_q + 1'b1;
			if (rd_data_s1 > max_acc_q) begin
				max_acc_q <= rd_data_s1;
			end
		end
	end

	wavgpk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_acc_q),
		.divisor  (cnt_acc_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// held statistics, updated when the division finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_h_q <= '0;
			max_h_q <= '0;
			cnt_h_q <= '0;
		end else if ((state_q == wavgpk_pkg::ST_DIV_WAIT) && div_stat.done) begin
			avg_h_q <= (cnt_acc_q == '0) ? '0 : div_quo[wavgpk_pkg::SAMPLE_BITS-1:0];
			max_h_q <= max_acc_q;
			cnt_h_q <= cnt_acc_q;
		end
	end

	// sample of the item in work
	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= sample_us;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_last_q <= samp_q;
			out_avg_q  <= avg_h_q;
			out_max_q  <= max_h_q;
			out_cnt_q  <= cnt_h_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign last_sample = out_last_q;
	assign average     = out_avg_q;
	assign maximum     = out_max_q;
	assign valid_count = out_cnt_q;

	// checks
	`WAPS_ASSERT_NOW(a_fill_bound, 1'b1,
		fill_q <= wavgpk_pkg::COUNT_BITS'(wavgpk_pkg::HISTORY_DEPTH))
	`WAPS_ASSERT_NOW(a_count_le_fill, state_q != wavgpk_pkg::ST_IDLE, cnt_acc_q <= fill_q)
	`WAPS_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy)
	`WAPS_ASSERT_NOW(a_peak_ge_avg, out_valid_q, out_max_q >= out_avg_q)
	`WAPS_ASSERT_NOW(a_empty_is_zero, out_valid_q && (out_cnt_q == '0),
		(out_max_q == '0) && (out_avg_q == '0))
	`WAPS_ASSERT_NEXT(a_walk_reads_tagged, rd_issue, rd_vld_s1)

endmodule
